/* rtl/box_blur_3x3_clamped_border_defines.svh */
// Assertion helpers for the RTL.
`ifndef BOX_BLUR_3X3_CLAMPED_BORDER_DEFINES_SVH
`define BOX_BLUR_3X3_CLAMPED_BORDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define BB3_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BB3_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bb3_pkg.sv */
`default_nettype none

package bb3_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int CFG_W       = 12;
    localparam int ROW_W       = 12;
    localparam int PIX_W       = 8;
    localparam int SUM_W       = 12;   // nine pixels: up to 2295
    localparam int CNT_W       = 4;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int CFG_ADDR_W  = 1;

    localparam logic [ROW_W-1:0] ROW_MAX      = {ROW_W{1'b1}};
    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);
    localparam logic [CFG_W-1:0] WIDTH_LIMIT  = CFG_W'(MAX_WIDTH);

    // register indexes on the config port
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // input kind carried in tuser
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV
    } state_t;

    typedef logic [PIX_W-1:0] pix_t;

    // ceil(2^16 / n): exact floor division for sums below 2^12
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        case (cnt)
            4'd1:    m = RECIP_W'(65536);
            4'd2:    m = RECIP_W'(32768);
            4'd3:    m = RECIP_W'(21846);
            4'd4:    m = RECIP_W'(16384);
            4'd6:    m = RECIP_W'(10923);
            4'd9:    m = RECIP_W'(7282);
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

/* rtl/bb3_ram.sv */
`default_nettype none

module bb3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/box_blur_3x3_clamped_border.sv */
// channel  dir  tdata             tuser        tlast        notes
// s_       in   pixel[7:0]        opcode[0]    -            raster pixels / drain ticks
// m_       out  blurred[7:0]      -            frame_last   one beat per emitted result
// cfg_     in   cfg_wdata[11:0]   -            -            idx 0 width, idx 1 height
//
// An ignored beat is only consumed; any other beat goes through line store read and
// window update and sum, and, if it gives a result, reciprocal multiply.
// The two line stores are single-port-write RAMs, read when a beat is accepted.
// Reset (aresetn low, synchronous) clears counters, window and control; line stores
// are not cleared. A stalled m_ beat holds the divide stage; one result may wait in
// the output register while the next input beat is taken.
`default_nettype none
`include "box_blur_3x3_clamped_border_defines.svh"

module box_blur_3x3_clamped_border (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,   // [7:0] pixel
    input  wire logic                             s_tuser,   // [0] opcode
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [7:0]                       m_tdata,   // [7:0] blurred
    output logic                                  m_tlast,
    input  wire logic                             cfg_wr_en,
    input  wire logic [bb3_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [bb3_pkg::CFG_W-1:0]        cfg_wdata
);

    localparam int COL_W = bb3_pkg::COL_W;
    localparam int ROW_W = bb3_pkg::ROW_W;
    localparam int CFG_W = bb3_pkg::CFG_W;
    localparam int SUM_W = bb3_pkg::SUM_W;
    localparam int CNT_W = bb3_pkg::CNT_W;

    bb3_pkg::state_t state_reg, state_next;

    logic [CFG_W-1:0] width_cfg_reg, height_cfg_reg;
    logic [COL_W-1:0] in_col_reg, out_col_reg;
    logic [ROW_W-1:0] in_row_reg, out_row_reg;
    bb3_pkg::pix_t    win_reg [3][3];
    bb3_pkg::pix_t    nw_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             last_reg;
    logic             m_valid_reg;
    bb3_pkg::pix_t    m_data_reg;
    logic             m_last_reg;

    logic [CFG_W-1:0] w_eff, h_eff;
    logic             accept, draining, ignore, emit;
    logic             in_last_col, out_last_col, out_last_row;
    logic             top_en, bot_en, left_en, right_en;
    logic [1:0]       rows, cols;
    logic [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0] cnt_next;
    logic             out_free;
    logic             ram_rd_en, ram_wr_en;
    bb3_pkg::pix_t    up_q, mid_q;
    logic [bb3_pkg::PROD_W-1:0] prod;

    // effective frame size
    always_comb begin
        if (width_cfg_reg == '0) begin
            w_eff = CFG_W'(1);
        end else if (width_cfg_reg > bb3_pkg::WIDTH_LIMIT) begin
            w_eff = bb3_pkg::WIDTH_LIMIT;
        end else begin
            w_eff = width_cfg_reg;
        end
        h_eff = (height_cfg_reg == '0) ? CFG_W'(1) : height_cfg_reg;
    end

    assign accept   = s_tvalid && s_tready;
    assign draining = in_row_reg >= h_eff;
    assign ignore   = !draining && (s_tuser == bb3_pkg::OP_DRAIN);
    assign emit     = (in_row_reg >= ROW_W'(2))
                   || (in_row_reg == ROW_W'(1) && in_col_reg != '0);
    assign out_free = !m_valid_reg || m_tready;

    assign in_last_col  = (CFG_W'(in_col_reg) + CFG_W'(1)) >= w_eff;
    assign out_last_col = (CFG_W'(out_col_reg) + CFG_W'(1)) >= w_eff;
    assign out_last_row = ({1'b0, out_row_reg} + (ROW_W+1)'(1)) >= {1'b0, h_eff};

    // neighborhood mask; center is window column 2, right is the incoming column
    assign top_en   = out_row_reg != '0;
    assign bot_en   = !out_last_row;
    assign left_en  = out_col_reg != '0;
    assign right_en = (in_col_reg != '0) && !out_last_col;
    assign rows     = 2'd1 + 2'(top_en) + 2'(bot_en);
    assign cols     = 2'd1 + 2'(left_en) + 2'(right_en);
    assign cnt_next = CNT_W'(rows) * CNT_W'(cols);

    always_comb begin
        bb3_pkg::pix_t rcol [3];
        logic          ren  [3];
        rcol[0] = up_q;
        rcol[1] = mid_q;
        rcol[2] = nw_reg;
        ren[0]  = top_en;
        ren[1]  = 1'b1;
        ren[2]  = bot_en;
        sum_next = '0;
        for (int r = 0; r < 3; r++) begin
            if (ren[r]) begin
                sum_next = sum_next + SUM_W'(win_reg[r][2]);
                if (left_en) begin
                    sum_next = sum_next + SUM_W'(win_reg[r][1]);
                end
                if (right_en) begin
                    sum_next = sum_next + SUM_W'(rcol[r]);
                end
            end
        end
    end

    assign prod = bb3_pkg::PROD_W'(sum_reg) * bb3_pkg::PROD_W'(bb3_pkg::recip(cnt_reg));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bb3_pkg::ST_IDLE: begin
                if (accept && !ignore) begin
                    state_next = bb3_pkg::ST_EXEC;
                end
            end
            bb3_pkg::ST_EXEC: begin
                state_next = emit ? bb3_pkg::ST_DIV : bb3_pkg::ST_IDLE;
            end
            bb3_pkg::ST_DIV: begin
                if (out_free) begin
                    state_next = bb3_pkg::ST_IDLE;
                end
            end
            default: state_next = bb3_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready  = 1'b0;
        ram_wr_en = 1'b0;
        unique case (state_reg)
            bb3_pkg::ST_IDLE: s_tready  = 1'b1;
            bb3_pkg::ST_EXEC: ram_wr_en = 1'b1;
            bb3_pkg::ST_DIV:  s_tready  = 1'b0;
            default:          s_tready  = 1'b0;
        endcase
    end

    assign ram_rd_en = accept && !ignore;

    bb3_ram #(
        .WIDTH (bb3_pkg::PIX_W),
        .DEPTH (bb3_pkg::MAX_WIDTH)
    ) u_upper_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (in_col_reg),
        .wr_data (mid_q),
        .rd_en   (ram_rd_en),
        .rd_addr (in_col_reg),
        .rd_data (up_q)
    );

    bb3_ram #(
        .WIDTH (bb3_pkg::PIX_W),
        .DEPTH (bb3_pkg::MAX_WIDTH)
    ) u_middle_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (in_col_reg),
        .wr_data (nw_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (in_col_reg),
        .rd_data (mid_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= bb3_pkg::ST_IDLE;
            width_cfg_reg  <= bb3_pkg::WIDTH_RESET;
            height_cfg_reg <= bb3_pkg::HEIGHT_RESET;
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            m_valid_reg    <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    bb3_pkg::REG_FRAME_WIDTH:  width_cfg_reg  <= cfg_wdata;
                    bb3_pkg::REG_FRAME_HEIGHT: height_cfg_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            if (state_reg == bb3_pkg::ST_EXEC) begin
                for (int r = 0; r < 3; r++) begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= up_q;
                win_reg[1][2] <= mid_q;
                win_reg[2][2] <= nw_reg;

                if (emit && out_last_row && out_last_col) begin
                    // frame done: everything rearms
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end else begin
                    if (in_last_col) begin
                        in_col_reg <= '0;
                        if (in_row_reg != bb3_pkg::ROW_MAX) begin
                            in_row_reg <= in_row_reg + ROW_W'(1);
                        end
                    end else begin
                        in_col_reg <= in_col_reg + COL_W'(1);
                    end
                    if (emit) begin
                        if (out_last_col) begin
                            out_col_reg <= '0;
                            if (out_row_reg != bb3_pkg::ROW_MAX) begin
                                out_row_reg <= out_row_reg + ROW_W'(1);
                            end
                        end else begin
                            out_col_reg <= out_col_reg + COL_W'(1);
                        end
                    end
                end
            end

            if (state_reg == bb3_pkg::ST_DIV && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            nw_reg <= draining ? '0 : s_tdata;
        end
        if (state_reg == bb3_pkg::ST_EXEC) begin
            sum_reg  <= sum_next;
            cnt_reg  <= cnt_next;
            last_reg <= out_last_row && out_last_col;
        end
        if (state_reg == bb3_pkg::ST_DIV && out_free) begin
            m_data_reg <= prod[bb3_pkg::RECIP_SHIFT +: bb3_pkg::PIX_W];
            m_last_reg <= last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    `BB3_ASSERT_NEXT(a_read_then_exec, aclk, aresetn, accept && !ignore, state_reg == bb3_pkg::ST_EXEC, "accepted beat did not reach exec")
    `BB3_ASSERT_NOW(a_divisor_legal, aclk, aresetn, state_reg == bb3_pkg::ST_DIV, cnt_reg == 4'd1 || cnt_reg == 4'd2 || cnt_reg == 4'd3 || cnt_reg == 4'd4 || cnt_reg == 4'd6 || cnt_reg == 4'd9, "bad neighbor count")
    `BB3_ASSERT_NOW(a_last_rearms, aclk, aresetn, state_reg == bb3_pkg::ST_DIV && last_reg, in_row_reg == '0 && in_col_reg == '0 && out_row_reg == '0 && out_col_reg == '0, "counters not rearmed after frame end")
    `BB3_ASSERT_NOW(a_col_in_range, aclk, aresetn, state_reg == bb3_pkg::ST_EXEC, emit || in_row_reg <= ROW_W'(1), "emit decode broken")

endmodule

`default_nettype wire
